FILE: rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared types, constants and helpers of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MAX_ORDER = 16;  // default upper bound on pool order
  localparam int OffW      = 16;  // quad offset width
  localparam int LinkW     = 17;  // link width, top bit marks an empty link
  localparam int OrdW      = 5;   // order / pool_order width
  localparam int SizeW     = 19;  // request size in words

  localparam logic [LinkW-1:0] NIL_LINK = 17'h10000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_OOM = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [SizeW-1:0] size_words;
    logic [OffW-1:0]  block_offset;
  } bba_req_t;

  typedef struct packed {
    logic [OffW-1:0] result_offset;
    logic            status;
  } bba_rsp_t;

  // one entry of the node memory
  typedef struct packed {
    logic [LinkW-1:0] nxt;
    logic [LinkW-1:0] prv;
    logic [OrdW-1:0]  ord;
  } bba_node_t;

  // memory port requests from the controller, full 16-bit addresses
  typedef struct packed {
    logic            nd_we;
    logic [OffW-1:0] nd_waddr;
    bba_node_t       nd_wdata;
    logic [OffW-1:0] nd_raddr;
    logic            bm_we;
    logic [OffW-1:0] bm_waddr;
    logic            bm_wdata;
    logic [OffW-1:0] bm_raddr;
  } bba_mem_req_t;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_A_SRCH,
    S_A_SPLIT,
    S_F_CHK,
    S_F_EVAL,
    S_F_MERGE,
    S_U_RD,
    S_U_GET,
    S_U_PRV,
    S_U_PWR,
    S_U_NXT,
    S_U_NWR,
    S_P_HD,
    S_P_LAST,
    S_P_HWR,
    S_DONE
  } bba_state_e;

  // words -> quads -> ceil(log2)
  function automatic logic [OrdW-1:0] size_to_order(input logic [SizeW-1:0] words);
    logic [SizeW:0]   sum;
    logic [SizeW-2:0] q;
    logic [SizeW-2:0] m;
    logic [OrdW-1:0]  k;
    sum = (SizeW+1)'(words) + (SizeW+1)'(3);
    q   = sum[SizeW:2];
    m   = q - (SizeW-1)'(1);
    k   = '0;
    if (q > (SizeW-1)'(1)) begin
      for (int i = 0; i < SizeW-1; i++) begin
        if (m[i]) k = OrdW'(i + 1);
      end
    end
    return k;
  endfunction

endpackage

FILE: rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// request sequencer: list heads, split / merge walk and list updates
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; #(
  parameter int MaxOrder = MAX_ORDER
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            init_i,
  input  logic [OrdW-1:0] pool_order_i,
  input  logic            start,
  output logic            busy,
  input  bba_req_t        req_i,
  output logic            rsp_valid_o,
  output bba_rsp_t        rsp_o,
  output bba_mem_req_t    mem_o,
  input  bba_node_t       nd_rdata_i,
  input  logic            bm_rdata_i
);

  localparam int OrdCap   = (MaxOrder < 16) ? MaxOrder : 16;
  localparam int NumLists = OrdCap + 1;
  localparam int LiW      = $clog2(NumLists);

  bba_state_e state_q, state_d, ret_q, ret_d;

  logic [LinkW-1:0]  heads_q [NumLists];
  logic              heads_we, heads_init;
  logic [LinkW-1:0]  heads_wdata;

  logic [OrdCap-1:0] cnt_q, cnt_d;
  logic [OrdW-1:0]   k_q, k_d, j_q, j_d, sord_q, sord_d;
  logic [OffW-1:0]   off_q, off_d, bud_q, bud_d, soff_q, soff_d;
  logic [LinkW-1:0]  h_q, h_d, p_q, p_d, n_q, n_d;
  logic [OffW-1:0]   res_off_q, res_off_d;
  logic              res_st_q, res_st_d;

  logic [OrdW-1:0]   req_k;
  logic [OffW-1:0]   pool_last, slast, bud_calc, fmask;
  logic              off_oor, clr_end, merge_ok;
  logic [LinkW-1:0]  head_j, head_s;

  assign req_k     = size_to_order(req_i.size_words);
  assign pool_last = OffW'((17'(1) << pool_order_i) - 17'd1);
  assign slast     = OffW'(17'(soff_q) + (17'(1) << sord_q) - 17'd1);
  assign bud_calc  = off_q ^ OffW'(17'(1) << k_q);
  assign fmask     = OffW'((17'(1) << req_k) - 17'd1);
  assign off_oor   = 17'(req_i.block_offset) >= (17'(1) << pool_order_i);
  assign clr_end   = OffW'(cnt_q) == pool_last;
  assign merge_ok  = bm_rdata_i && (nd_rdata_i.ord == k_q);
  assign head_j    = heads_q[j_q[LiW-1:0]];
  assign head_s    = heads_q[sord_q[LiW-1:0]];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:     if (clr_end) state_d = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (req_i.opcode == OP_ALLOC) state_d = S_A_SRCH;
          else if (req_k > pool_order_i || off_oor) state_d = S_DONE;
          else state_d = S_F_CHK;
        end
      end
      S_A_SRCH: begin
        if (j_q > pool_order_i) state_d = S_DONE;
        else if (!head_j[LinkW-1]) state_d = S_U_RD;
      end
      S_A_SPLIT: state_d = (j_q > k_q) ? S_P_HD : S_DONE;
      S_F_CHK:   state_d = (k_q < pool_order_i) ? S_F_EVAL : S_P_HD;
      S_F_EVAL:  state_d = merge_ok ? S_U_RD : S_P_HD;
      S_F_MERGE: state_d = S_F_CHK;
      S_U_RD:    state_d = S_U_GET;
      S_U_GET:   state_d = S_U_PRV;
      S_U_PRV:   state_d = p_q[LinkW-1] ? S_U_NXT : S_U_PWR;
      S_U_PWR:   state_d = S_U_NXT;
      S_U_NXT:   state_d = n_q[LinkW-1] ? ret_q : S_U_NWR;
      S_U_NWR:   state_d = ret_q;
      S_P_HD:    state_d = S_P_LAST;
      S_P_LAST:  state_d = h_q[LinkW-1] ? ret_q : S_P_HWR;
      S_P_HWR:   state_d = ret_q;
      S_DONE:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
    if (init_i) state_d = S_CLR;
  end

  // datapath and memory ports
  always_comb begin
    cnt_d = cnt_q;  k_d = k_q;  j_d = j_q;  sord_d = sord_q;
    off_d = off_q;  bud_d = bud_q;  soff_d = soff_q;  ret_d = ret_q;
    h_d = h_q;  p_d = p_q;  n_d = n_q;
    res_off_d = res_off_q;  res_st_d = res_st_q;
    heads_we = 1'b0;  heads_init = 1'b0;  heads_wdata = NIL_LINK;
    mem_o = '0;
    unique case (state_q)
      S_CLR: begin
        mem_o.bm_we    = 1'b1;
        mem_o.bm_waddr = OffW'(cnt_q);
        mem_o.bm_wdata = (cnt_q == '0) || clr_end;
        if (cnt_q == '0) begin
          mem_o.nd_we    = 1'b1;
          mem_o.nd_waddr = '0;
          mem_o.nd_wdata = '{nxt: NIL_LINK, prv: NIL_LINK, ord: pool_order_i};
        end
        cnt_d = cnt_q + 1'b1;
        if (clr_end) heads_init = 1'b1;
      end
      S_IDLE: begin
        if (start) begin
          k_d       = req_k;
          j_d       = req_k;
          off_d     = req_i.block_offset & ~fmask;
          res_off_d = '0;
          res_st_d  = ST_OK;
        end
      end
      S_A_SRCH: begin
        if (j_q > pool_order_i) begin
          res_st_d = ST_OOM;
        end else if (head_j[LinkW-1]) begin
          j_d = j_q + 1'b1;
        end else begin
          sord_d = j_q;
          soff_d = head_j[OffW-1:0];
          off_d  = head_j[OffW-1:0];
          ret_d  = S_A_SPLIT;
        end
      end
      S_A_SPLIT: begin
        if (j_q > k_q) begin
          j_d    = j_q - 1'b1;
          sord_d = j_q - 1'b1;
          soff_d = off_q + OffW'(17'(1) << (j_q - 5'd1));
          ret_d  = S_A_SPLIT;
        end else begin
          res_off_d = off_q;
        end
      end
      S_F_CHK: begin
        if (k_q < pool_order_i) begin
          mem_o.nd_raddr = bud_calc;
          mem_o.bm_raddr = bud_calc;
          bud_d          = bud_calc;
        end else begin
          sord_d = k_q;  soff_d = off_q;  ret_d = S_DONE;
        end
      end
      S_F_EVAL: begin
        sord_d = k_q;
        if (merge_ok) begin
          soff_d = bud_q;  ret_d = S_F_MERGE;
        end else begin
          soff_d = off_q;  ret_d = S_DONE;
        end
      end
      S_F_MERGE: begin
        if (bud_q < off_q) off_d = bud_q;
        k_d = k_q + 1'b1;
      end
      S_U_RD: mem_o.nd_raddr = soff_q;
      S_U_GET: begin
        p_d            = nd_rdata_i.prv;
        n_d            = nd_rdata_i.nxt;
        mem_o.bm_we    = 1'b1;
        mem_o.bm_waddr = soff_q;
        mem_o.bm_wdata = 1'b0;
      end
      S_U_PRV: begin
        mem_o.bm_we    = 1'b1;
        mem_o.bm_waddr = slast;
        mem_o.bm_wdata = 1'b0;
        if (p_q[LinkW-1]) begin
          heads_we    = 1'b1;
          heads_wdata = n_q;
        end else begin
          mem_o.nd_raddr = p_q[OffW-1:0];
        end
      end
      S_U_PWR: begin
        mem_o.nd_we    = 1'b1;
        mem_o.nd_waddr = p_q[OffW-1:0];
        mem_o.nd_wdata = '{nxt: n_q, prv: nd_rdata_i.prv, ord: nd_rdata_i.ord};
      end
      S_U_NXT: mem_o.nd_raddr = n_q[OffW-1:0];
      S_U_NWR: begin
        mem_o.nd_we    = 1'b1;
        mem_o.nd_waddr = n_q[OffW-1:0];
        mem_o.nd_wdata = '{nxt: nd_rdata_i.nxt, prv: p_q, ord: nd_rdata_i.ord};
      end
      S_P_HD: begin
        h_d            = head_s;
        mem_o.nd_we    = 1'b1;
        mem_o.nd_waddr = soff_q;
        mem_o.nd_wdata = '{nxt: head_s, prv: NIL_LINK, ord: sord_q};
        mem_o.bm_we    = 1'b1;
        mem_o.bm_waddr = soff_q;
        mem_o.bm_wdata = 1'b1;
        heads_we       = 1'b1;
        heads_wdata    = {1'b0, soff_q};
      end
      S_P_LAST: begin
        mem_o.bm_we    = 1'b1;
        mem_o.bm_waddr = slast;
        mem_o.bm_wdata = 1'b1;
        mem_o.nd_raddr = h_q[OffW-1:0];
      end
      S_P_HWR: begin
        mem_o.nd_we    = 1'b1;
        mem_o.nd_waddr = h_q[OffW-1:0];
        mem_o.nd_wdata = '{nxt: nd_rdata_i.nxt, prv: {1'b0, soff_q}, ord: nd_rdata_i.ord};
      end
      S_DONE: ;
      default: ;
    endcase
    if (init_i) cnt_d = '0;
  end

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = (state_q == S_DONE);
  assign rsp_o       = '{result_offset: res_off_q, status: res_st_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      ret_q    <= S_DONE;
      cnt_q    <= '0;
      res_st_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      cnt_q    <= cnt_d;
      res_st_q <= res_st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;  j_q <= j_d;  sord_q <= sord_d;
    off_q <= off_d;  bud_q <= bud_d;  soff_q <= soff_d;
    h_q <= h_d;  p_q <= p_d;  n_q <= n_d;
    res_off_q <= res_off_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLists; i++) heads_q[i] <= NIL_LINK;
    end else if (heads_init) begin
      for (int i = 0; i < NumLists; i++) begin
        heads_q[i] <= (OrdW'(i) == pool_order_i) ? '0 : NIL_LINK;
      end
    end else if (heads_we) begin
      heads_q[sord_q[LiW-1:0]] <= heads_wdata;
    end
  end

endmodule

FILE: rtl/buddy_block_allocator_top.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// binary buddy allocator over a pool of quad-word units
// ----------------------------------------------------------------------------
// channel    direction  handshake             word
// request    in         start & !busy         req_i (opcode, size_words, block_offset)
// response   out        rsp_valid_o, 1 cycle  rsp_o (result_offset, status)
// config     in         cfg_we_i              cfg_wdata_i (pool_order)
//
// request duration depends on its kind: an ignored free, a plain push on free,
//   an allocate with its search steps, the unlink and one push per split, or a
//   free with one pass per merge step; it is set by the one read port of the
//   node memory and its read-modify-write per list update
// reset and every pool_order write start a clearing pass over 2^pool_order
//   entries of the free bitmap; busy stays high meanwhile
// the response strobe lasts one cycle and cannot be held off
// ----------------------------------------------------------------------------
module buddy_block_allocator_top import bba_pkg::*; #(
  parameter int MaxOrder = MAX_ORDER
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  bba_req_t        req_i,
  output logic            rsp_valid_o,
  output bba_rsp_t        rsp_o,
  input  logic            cfg_we_i,
  input  logic [OrdW-1:0] cfg_wdata_i
);

  localparam int OrdCap = (MaxOrder < 16) ? MaxOrder : 16;
  localparam int Depth  = 2 ** OrdCap;
  localparam logic [OrdW-1:0] PoolRst = OrdW'((OrdCap < 8) ? OrdCap : 8);

  logic [OrdW-1:0] pool_order_q, pool_order_d;
  bba_mem_req_t    mem_req;
  bba_node_t       nd_rdata;
  logic            bm_rdata;

  // pool order saturates at the memory size
  assign pool_order_d = (cfg_wdata_i > OrdW'(OrdCap)) ? OrdW'(OrdCap) : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_order_q <= PoolRst;
    end else if (cfg_we_i) begin
      pool_order_q <= pool_order_d;
    end
  end

  // sequencer: heads, split / merge walk, clearing pass
  bba_ctrl #(
    .MaxOrder(MaxOrder)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_i      (cfg_we_i),
    .pool_order_i(pool_order_q),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .mem_o       (mem_req),
    .nd_rdata_i  (nd_rdata),
    .bm_rdata_i  (bm_rdata)
  );

  // node memory: next link, prev link and order of each free block head
  bba_ram #(
    .Width($bits(bba_node_t)),
    .Depth(Depth)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (mem_req.nd_we),
    .waddr_i(mem_req.nd_waddr[OrdCap-1:0]),
    .wdata_i(mem_req.nd_wdata),
    .raddr_i(mem_req.nd_raddr[OrdCap-1:0]),
    .rdata_o(nd_rdata)
  );

  // free bitmap: first and last quad of each free block
  bba_ram #(
    .Width(1),
    .Depth(Depth)
  ) u_bitmap_ram (
    .clk_i  (clk_i),
    .we_i   (mem_req.bm_we),
    .waddr_i(mem_req.bm_waddr[OrdCap-1:0]),
    .wdata_i(mem_req.bm_wdata),
    .raddr_i(mem_req.bm_raddr[OrdCap-1:0]),
    .rdata_o(bm_rdata)
  );

endmodule
